// ===== rtl/core/bitmap_block_allocator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap block allocator
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int WORD_W         = 32;
  localparam int BLK_W          = 10;
  localparam int CNT_OUT_W      = 11;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_TEST  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic                 status;
    logic [BLK_W-1:0]     granted_block;
    logic                 old_bit;
    logic [CNT_OUT_W-1:0] free_count;
  } res_t;

endpackage

// ===== rtl/core/bba_map_ram.sv =====
// ----------------------------------------------------------------------------
// bba_map_ram
// Word-wide used-bit map: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bba_map_ram import bba_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clears the map after reset, scans words for allocate, does
// read-modify-write of one word for free and reads one word for test.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int WORD_COUNT = (NUM_BLOCKS + WORD_W - 1) / WORD_W,
  parameter int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [BLK_W-1:0]   block_number,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res,
  output logic               wr_en,
  output logic [WORD_AW-1:0] wr_addr,
  output logic [WORD_W-1:0]  wr_data,
  output logic               rd_en,
  output logic [WORD_AW-1:0] rd_addr,
  input  logic [WORD_W-1:0]  rd_data
);

  localparam int          CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [31:0] NUM_L = 32'(NUM_BLOCKS);

  function automatic logic [4:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [4:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = 5'(i);
      end
    end
    return pos;
  endfunction

  st_t                state, state_next;
  logic [WORD_AW-1:0] clr_idx, clr_idx_next;
  logic [WORD_AW-1:0] scan_idx, scan_idx_next;
  logic [1:0]         act, act_next;
  logic [BLK_W-1:0]   blk, blk_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               status, status_next;
  logic [BLK_W-1:0]   granted, granted_next;
  logic               old_bit, old_bit_next;

  logic [15:0]        in_word, blk_word;
  logic               in_range;
  logic [4:0]         pos;
  logic [31:0]        gnt_full;
  logic [31:0]        cnt_full;
  logic               bit_now;

  assign in_word  = {11'd0, block_number[9:5]};
  assign blk_word = {11'd0, blk[9:5]};
  assign in_range = {22'd0, block_number} < NUM_L;
  assign pos      = lowest_zero(rd_data);
  assign gnt_full = 32'({scan_idx, pos});
  assign cnt_full = 32'(count);
  assign bit_now  = rd_data[blk[4:0]];

  assign res.status        = status;
  assign res.granted_block = granted;
  assign res.old_bit       = old_bit;
  assign res.free_count    = cnt_full[CNT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      count   <= CNT_W'(NUM_BLOCKS);
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    act      <= act_next;
    blk      <= blk_next;
    status   <= status_next;
    granted  <= granted_next;
    old_bit  <= old_bit_next;
  end

  always_comb begin
    state_next    = state;
    clr_idx_next  = clr_idx;
    scan_idx_next = scan_idx;
    act_next      = act;
    blk_next      = blk;
    count_next    = count;
    status_next   = status;
    granted_next  = granted;
    old_bit_next  = old_bit;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = scan_idx;
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = scan_idx;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
        if (clr_idx == WORD_AW'(WORD_COUNT - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_idx_next = clr_idx + WORD_AW'(1);
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_next     = action;
          blk_next     = block_number;
          status_next  = 1'b0;
          granted_next = '0;
          old_bit_next = 1'b0;
          state_next   = ST_DONE;
          case (action)
            ACT_ALLOC: begin
              if (count == '0) begin
                status_next = 1'b1;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = '0;
                scan_idx_next = '0;
                state_next    = ST_SCAN;
              end
            end
            ACT_FREE, ACT_TEST: begin
              if (in_range) begin
                rd_en      = 1'b1;
                rd_addr    = in_word[WORD_AW-1:0];
                state_next = ST_READ;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_data != '1) begin
          wr_en        = 1'b1;
          wr_addr      = scan_idx;
          wr_data      = rd_data | (WORD_W'(1) << pos);
          count_next   = count - CNT_W'(1);
          granted_next = gnt_full[BLK_W-1:0];
          state_next   = ST_DONE;
        end else begin
          scan_idx_next = scan_idx + WORD_AW'(1);
          rd_en         = 1'b1;
          rd_addr       = scan_idx + WORD_AW'(1);
        end
      end
      ST_READ: begin
        old_bit_next = bit_now;
        if (act == ACT_FREE && bit_now) begin
          wr_en      = 1'b1;
          wr_addr    = blk_word[WORD_AW-1:0];
          wr_data    = rd_data & ~(WORD_W'(1) << blk[4:0]);
          count_next = count + CNT_W'(1);
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bitmap_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a one-bit-per-block used map.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the action (allocate,
// free, test) and s_tdata the block number. Each request gives exactly one
// response on the m_ stream with status, granted block, old bit and the free
// count after the request.
// The map is held in a memory of 32-bit words with a registered read. A free or
// test reads its word in ST_READ before the response, or goes straight to the
// response when the block number is out of range. An allocate scans the words
// from the lowest one up, one word per cycle, up to the first word with a free
// bit (32 words with 1024 blocks). A failing allocate or an idle action goes
// straight to the response. s_tready rises again in the cycle after the
// response is loaded, so a new request is taken only once the last one is done.
// After reset a clearing pass writes every map word to zero, one word per
// cycle (32 words with 1024 blocks); s_tready stays low during it.
// Responses sit in an output register. While the receiver stalls, one more
// request is taken and worked on; it waits finished until the register frees.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_core_defines.svh"

module bitmap_block_allocator_core import bba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] block_number, [15:10] zero
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [9:0] granted_block, [10] old_bit,
                                 // [21:11] free_count, [23:22] zero
  output logic [0:0]  m_tuser    // [0] status
);

  localparam int WORD_COUNT = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic               res_valid, res_ready;
  res_t               res, res_q;
  logic               wr_en, rd_en;
  logic [WORD_AW-1:0] wr_addr, rd_addr;
  logic [WORD_W-1:0]  wr_data, rd_data;

  bba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_COUNT (WORD_COUNT),
    .WORD_AW    (WORD_AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .action       (s_tuser),
    .block_number (s_tdata[BLK_W-1:0]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  bba_map_ram #(
    .DEPTH (WORD_COUNT),
    .AW    (WORD_AW)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign m_tdata    = {2'b00, res_q.free_count, res_q.old_bit, res_q.granted_block};
  assign m_tuser[0] = res_q.status;

  `BBA_ASSERT_NOW(a_ready_excl, s_tready, !res_valid && !rd_en || s_tvalid,
    "Sequencer takes a request while a response is pending.")
  `BBA_ASSERT_NOW(a_fail_empty, m_tvalid && res_q.status,
    res_q.granted_block == '0 && res_q.old_bit == 1'b0,
    "Failed allocate carries a block number or old bit.")
  `BBA_ASSERT_NEXT(a_load_shows, res_valid && res_ready, m_tvalid,
    "Loaded response is not presented on the output.")

endmodule

// ===== tb/bitmap_block_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_tb
// Checks the first-fit block allocator against a cycle-free predictor of the
// used map and free count. Requests stream in with random gaps, responses are
// taken with random stalls and one long hold-off, and every response is
// compared field by field with the predicted one.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core_tb;
  import bba_pkg::*;

  localparam int NUM_BLOCKS = NUM_BLOCKS_DEF;
  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_AT_RESULT = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [1:0] action;
    logic [9:0] block;
  } alloc_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;

  bitmap_block_allocator_core #(.NUM_BLOCKS(NUM_BLOCKS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alloc_req_t request_q[$];
  res_t       response_q[$];
  alloc_req_t cur_req;

  logic [NUM_BLOCKS-1:0] shadow_used;
  int unsigned           shadow_free;

  int errors = 0;
  int tx_count = 0;
  int tx_gap = 0;
  int rx_count = 0;
  int rx_wait = 0;
  int cycles = 0;
  logic hold_on = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;

  function automatic res_t predict_allocator_response(logic [1:0] act, logic [9:0] blk);
    res_t r;
    logic found;
    r = '0;
    found = 1'b0;
    case (act)
      ACT_ALLOC: begin
        if (shadow_free != 0) begin
          for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (!found && !shadow_used[b]) begin
              found = 1'b1;
              shadow_used[b] = 1'b1;
              shadow_free--;
              r.granted_block = BLK_W'(b);
            end
          end
        end
        if (!found) r.status = 1'b1;
      end
      ACT_FREE: begin
        if (int'(blk) < NUM_BLOCKS) begin
          r.old_bit = shadow_used[blk];
          if (shadow_used[blk]) begin
            shadow_used[blk] = 1'b0;
            shadow_free++;
          end
        end
      end
      ACT_TEST: begin
        if (int'(blk) < NUM_BLOCKS) r.old_bit = shadow_used[blk];
      end
      default: ;
    endcase
    r.free_count = CNT_OUT_W'(shadow_free);
    return r;
  endfunction

  function automatic void push_request(logic [1:0] act, logic [9:0] blk);
    alloc_req_t q;
    q.action = act;
    q.block = blk;
    request_q.push_back(q);
  endfunction

  function automatic logic [9:0] random_block();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 10'd0;
    if (sel == 1) return 10'd1023;
    return 10'($urandom_range(0, NUM_BLOCKS - 1));
  endfunction

  function automatic int draw_wait(int seq);
    if ((seq / 128) % 4 == 3) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on response %0d: %s got %0d expected %0d",
             rx_count, field, got, want);
    errors++;
  endtask

  // Request driver: holds the current transfer until accepted, then waits
  // out a drawn gap before offering the next pending request.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        response_q.push_back(predict_allocator_response(cur_req.action, cur_req.block));
        tx_count <= tx_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          s_tuser <= cur_req.action;
          s_tdata <= {6'd0, cur_req.block};
          s_tvalid <= 1'b1;
          tx_gap <= draw_wait(tx_count);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random receiver stalls.
  always @(posedge clk) begin
    int next_wait;
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      next_wait = (rx_wait > 0) ? rx_wait - 1 : 0;
      if (m_tvalid && m_tready) begin
        if (response_q.size() == 0) begin
          $display("response %0d arrived with none expected", rx_count);
          errors++;
        end else begin
          want = response_q.pop_front();
          if (m_tuser[0] !== want.status)
            report_mismatch("status", m_tuser[0], want.status);
          if (m_tdata[9:0] !== want.granted_block)
            report_mismatch("granted_block", m_tdata[9:0], want.granted_block);
          if (m_tdata[10] !== want.old_bit)
            report_mismatch("old_bit", m_tdata[10], want.old_bit);
          if (m_tdata[21:11] !== want.free_count)
            report_mismatch("free_count", m_tdata[21:11], want.free_count);
        end
        rx_count <= rx_count + 1;
        next_wait = draw_wait(rx_count);
      end
      rx_wait <= next_wait;
      m_tready <= (next_wait == 0) && !hold_on;
    end
  end

  // One long receiver hold-off so that the block fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_on <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt <= 0;
    end else if (!hold_done && rx_count >= HOLD_AT_RESULT) begin
      hold_on <= 1'b1;
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_on <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL bitmap_block_allocator_core");
      $finish;
    end
  end

  initial begin
    int pick;
    logic [1:0] act;
    shadow_used = '0;
    shadow_free = NUM_BLOCKS;

    // Directed: edge block numbers, frees of free blocks, the idle code,
    // allocation order and reuse of a freed block.
    push_request(ACT_TEST, 10'd0);
    push_request(ACT_TEST, 10'd1023);
    push_request(ACT_FREE, 10'd0);
    push_request(ACT_FREE, 10'd1023);
    push_request(ACT_NOP, 10'd1023);
    push_request(ACT_ALLOC, 10'd1023);
    push_request(ACT_ALLOC, 10'd0);
    push_request(ACT_ALLOC, 10'd555);
    push_request(ACT_TEST, 10'd1);
    push_request(ACT_FREE, 10'd1);
    push_request(ACT_TEST, 10'd1);
    push_request(ACT_FREE, 10'd1);
    push_request(ACT_ALLOC, 10'd0);
    push_request(ACT_TEST, 10'd2);
    push_request(ACT_NOP, 10'd0);
    push_request(ACT_FREE, 10'd0);
    push_request(ACT_ALLOC, 10'd1023);
    push_request(ACT_TEST, 10'd3);
    push_request(ACT_FREE, 10'd2);
    push_request(ACT_ALLOC, 10'd0);

    // Random: fill the map past full, free part of it, then a balanced mix.
    for (int i = 0; i < 1900; i++) begin
      pick = $urandom_range(0, 99);
      if (i < 1150) begin
        act = (pick < 92) ? ACT_ALLOC : (pick < 98) ? ACT_TEST :
              (pick < 99) ? ACT_FREE : ACT_NOP;
      end else if (i < 1550) begin
        act = (pick < 70) ? ACT_FREE : (pick < 85) ? ACT_ALLOC :
              (pick < 95) ? ACT_TEST : ACT_NOP;
      end else begin
        act = (pick < 40) ? ACT_ALLOC : (pick < 75) ? ACT_FREE :
              (pick < 95) ? ACT_TEST : ACT_NOP;
      end
      push_request(act, random_block());
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() > 0 || s_tvalid || response_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (response_q.size() != 0) begin
      $display("%0d expected responses never arrived", response_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS bitmap_block_allocator_core");
    end else begin
      $display("FAIL bitmap_block_allocator_core");
    end
    $finish;
  end

endmodule

// ===== bitmap_block_allocator_core.f =====
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_map_ram.sv
rtl/core/bba_ctrl.sv
rtl/core/bitmap_block_allocator_core.sv
tb/bitmap_block_allocator_core_tb.sv
